@@ hdl/jitl_pkg.sv @@
`default_nettype none

package jitl_pkg;

  // Joint count and field widths
  localparam int JointsDef = 7;
  localparam int JointW    = 3;
  localparam int SigW      = 24;
  localparam int GainW     = 16;
  localparam int CfgDataW  = 64;
  localparam int CfgIdxW   = 3;

  // Configuration register reset values
  localparam logic [15:0] CoriolisScaleRst = 16'd16384;
  localparam logic [22:0] StepLimitRst     = 23'd65536;
  localparam logic [16:0] FilterWeightRst  = 17'd64881;
  localparam logic [16:0] FilterWeightOne  = 17'd65536;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_STIFF_LO  = 3'd0,
    REG_STIFF_HI  = 3'd1,
    REG_DAMP_LO   = 3'd2,
    REG_DAMP_HI   = 3'd3,
    REG_COR_SCALE = 3'd4,
    REG_STEP_LIM  = 3'd5,
    REG_FLT_WGT   = 3'd6
  } cfg_reg_e;

  // Pick the Q12.4 gain of one joint out of the packed low and high words
  function automatic logic [GainW-1:0] gain_sel(input logic [63:0] lo,
                                                input logic [47:0] hi,
                                                input logic [JointW-1:0] j);
    logic [GainW-1:0] g;
    case (j)
      3'd0:    g = lo[15:0];
      3'd1:    g = lo[31:16];
      3'd2:    g = lo[47:32];
      3'd3:    g = lo[63:48];
      3'd4:    g = hi[15:0];
      3'd5:    g = hi[31:16];
      3'd6:    g = hi[47:32];
      default: g = '0;
    endcase
    return g;
  endfunction

  // Saturate a wide signed value to the 24-bit signal range
  function automatic logic signed [SigW-1:0] sat24(input logic signed [47:0] x);
    logic signed [SigW-1:0] r;
    if (x > 48'sd8388607) begin
      r = 24'sh7FFFFF;
    end else if (x < -48'sd8388608) begin
      r = 24'sh800000;
    end else begin
      r = x[SigW-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ hdl/joint_impedance_torque_law.sv @@
// Joint impedance torque law with torque step limit.
//
// Input channel (in_valid_i / in_stall_o) takes one joint sample per transfer;
// output channel (out_valid_o / out_stall_i) returns one result per sample:
// the echoed joint, the clamped torque command and a flag that the step
// clamp acted. The configuration port writes one register per cycle at
// cfg_we_i; write only while no sample is in flight.
//
// The result is registered in the output register at the clamp step. A new sample is
// taken in the cycle the previous one loads the output register, so the
// block takes one sample at a time through the four-step sequencer
// around the filtered-velocity memory (multiply, filter, sum, clamp).
// A result waiting in the output register does not block the next sample;
// only when it is still stalled at the clamp step does the sequencer hold.
//
// Reset clears the sequencer and the output valid, loads the configuration
// registers with their reset values and clears the per-joint valid bits: a
// joint never written reads a filtered velocity of zero. A joint index at or
// above JOINTS returns zero torque and leaves the memory untouched.
`default_nettype none

module joint_impedance_torque_law #(
  parameter int JOINTS = jitl_pkg::JointsDef
) (
  input  wire                                       clk_i,
  input  wire                                       rst_ni,
  // configuration
  input  wire                                       cfg_we_i,
  input  wire        [jitl_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  wire        [jitl_pkg::CfgDataW-1:0]       cfg_data_i,
  // input samples
  input  wire                                       in_valid_i,
  output logic                                      in_stall_o,
  input  wire        [jitl_pkg::JointW-1:0]         joint_i,
  input  wire signed [jitl_pkg::SigW-1:0]           position_i,
  input  wire signed [jitl_pkg::SigW-1:0]           position_target_i,
  input  wire signed [jitl_pkg::SigW-1:0]           velocity_i,
  input  wire signed [jitl_pkg::SigW-1:0]           velocity_target_i,
  input  wire signed [jitl_pkg::SigW-1:0]           coriolis_torque_i,
  input  wire signed [jitl_pkg::SigW-1:0]           previous_command_i,
  // results
  output logic                                      out_valid_o,
  input  wire                                       out_stall_i,
  output logic       [jitl_pkg::JointW-1:0]         joint_out_o,
  output logic signed [jitl_pkg::SigW-1:0]          torque_command_o,
  output logic                                      rate_limited_o
);
  import jitl_pkg::*;

  localparam int IdxW = (JOINTS > 1) ? $clog2(JOINTS) : 1;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_MUL   = 5'b00010,
    ST_FILT  = 5'b00100,
    ST_SUM   = 5'b01000,
    ST_CLAMP = 5'b10000
  } state_e;

  state_e st_q, st_d;

  // Configuration registers
  logic [63:0] stiff_lo_q, damp_lo_q;
  logic [47:0] stiff_hi_q, damp_hi_q;
  logic [15:0] cor_scale_q;
  logic [22:0] step_lim_q;
  logic [16:0] flt_wgt_q;

  // Item registers
  logic [JointW-1:0]        joint_q;
  logic                     joint_ok_q;
  logic signed [24:0]       perr_q;
  logic signed [SigW-1:0]   vel_q, vt_q, cor_q, prev_q;

  // Filtered-velocity memory and valid bits
  logic signed [SigW-1:0]   fv_mem [JOINTS];
  logic [JOINTS-1:0]        fv_vld_q;
  logic signed [SigW-1:0]   rd_data_q;
  logic                     rd_vld_q;

  // Arithmetic pipeline registers
  logic signed [41:0]       acc_q;
  logic signed [38:0]       csum_q;
  logic signed [26:0]       cterm_q;
  logic signed [37:0]       kterm_q;
  logic signed [SigW-1:0]   fnew_q;
  logic signed [SigW-1:0]   sum_q;

  // Output register
  logic                     out_valid_q;
  logic [JointW-1:0]        joint_out_q;
  logic signed [SigW-1:0]   torque_q;
  logic                     limited_q;

  logic                     in_xfer, out_free, joint_ok, wr_en;
  logic [IdxW-1:0]          in_idx, wr_idx;
  logic [16:0]              w_eff;
  logic [GainW-1:0]         k_gain, d_gain;

  // Combinational arithmetic
  logic signed [SigW-1:0]   f_old;
  logic signed [41:0]       mul_a, mul_b, kmul, dmul;
  logic signed [40:0]       cmul;
  logic signed [42:0]       fsum;
  logic signed [SigW-1:0]   fnew;
  logic signed [24:0]       verr;
  logic signed [39:0]       tsum;
  logic signed [24:0]       diff, lim_s, ldiff;
  logic                     limited;
  logic signed [25:0]       tq_wide;
  logic signed [SigW-1:0]   tq;

  assign out_free = !out_valid_q || !out_stall_i;
  assign in_stall_o = !((st_q == ST_IDLE) || ((st_q == ST_CLAMP) && out_free));
  assign in_xfer  = in_valid_i && !in_stall_o;
  assign joint_ok = (32'(joint_i) < JOINTS);
  assign in_idx   = joint_i[IdxW-1:0];
  assign wr_idx   = joint_q[IdxW-1:0];
  assign wr_en    = (st_q == ST_FILT) && joint_ok_q;

  assign w_eff  = (flt_wgt_q > FilterWeightOne) ? FilterWeightOne : flt_wgt_q;
  assign k_gain = gain_sel(stiff_lo_q, stiff_hi_q, joint_q);
  assign d_gain = gain_sel(damp_lo_q, damp_hi_q, joint_q);

  // Step 1: old-sample product, Coriolis and stiffness terms
  assign f_old   = rd_vld_q ? rd_data_q : '0;
  assign mul_a   = $signed({1'b0, 17'(FilterWeightOne - w_eff)}) * f_old;
  assign cmul    = cor_q * $signed({1'b0, cor_scale_q});
  assign kmul    = $signed({1'b0, k_gain}) * perr_q;

  // Step 2: new-sample product, round and saturate the filter
  assign mul_b = $signed({1'b0, w_eff}) * vel_q;
  assign fsum  = 43'(acc_q) + 43'(mul_b) + 43'sd32768;
  assign fnew  = sat24(48'($signed(fsum[42:16])));

  // Step 3: rounded damping term and saturated sum
  assign verr = 25'(vt_q) - 25'(fnew_q);
  assign dmul = $signed({1'b0, d_gain}) * verr;
  assign tsum = 40'(csum_q) + 40'((43'(dmul) + 43'sd8) >>> 4);

  // Step 4: clamp the change against the last command
  assign diff  = 25'(sum_q) - 25'(prev_q);
  assign lim_s = $signed({2'b00, step_lim_q});
  always_comb begin
    ldiff   = diff;
    limited = 1'b0;
    if (diff > lim_s) begin
      ldiff   = lim_s;
      limited = 1'b1;
    end else if (diff < -lim_s) begin
      ldiff   = -lim_s;
      limited = 1'b1;
    end
  end
  assign tq_wide = 26'(prev_q) + 26'(ldiff);
  assign tq      = sat24(48'(tq_wide));

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stiff_lo_q  <= '0;
      stiff_hi_q  <= '0;
      damp_lo_q   <= '0;
      damp_hi_q   <= '0;
      cor_scale_q <= CoriolisScaleRst;
      step_lim_q  <= StepLimitRst;
      flt_wgt_q   <= FilterWeightRst;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_STIFF_LO:  stiff_lo_q  <= cfg_data_i;
        REG_STIFF_HI:  stiff_hi_q  <= cfg_data_i[47:0];
        REG_DAMP_LO:   damp_lo_q   <= cfg_data_i;
        REG_DAMP_HI:   damp_hi_q   <= cfg_data_i[47:0];
        REG_COR_SCALE: cor_scale_q <= cfg_data_i[15:0];
        REG_STEP_LIM:  step_lim_q  <= cfg_data_i[22:0];
        REG_FLT_WGT:   flt_wgt_q   <= cfg_data_i[16:0];
        default: ;
      endcase
    end
  end

  // Advance the sequencer
  always_comb begin
    st_d = st_q;
    case (st_q)
      ST_IDLE:  if (in_xfer) st_d = ST_MUL;
      ST_MUL:   st_d = ST_FILT;
      ST_FILT:  st_d = ST_SUM;
      ST_SUM:   st_d = ST_CLAMP;
      ST_CLAMP: begin
        if (out_free) begin
          st_d = in_xfer ? ST_MUL : ST_IDLE;
        end
      end
      default:  st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  // Capture the sample on transfer
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      joint_q    <= joint_i;
      joint_ok_q <= joint_ok;
      perr_q     <= 25'(position_target_i) - 25'(position_i);
      vel_q      <= velocity_i;
      vt_q       <= velocity_target_i;
      cor_q      <= coriolis_torque_i;
      prev_q     <= previous_command_i;
    end
  end

  // Read at transfer, write back after the filter step
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      rd_data_q <= fv_mem[in_idx];
    end
    if (wr_en) begin
      fv_mem[wr_idx] <= fnew;
    end
  end

  // Track written entries; an unwritten joint reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_vld_q <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (in_xfer) begin
        rd_vld_q <= joint_ok && fv_vld_q[in_idx];
      end
      if (wr_en) begin
        fv_vld_q[wr_idx] <= 1'b1;
      end
    end
  end

  // Hold the arithmetic between steps
  always_ff @(posedge clk_i) begin
    if (st_q == ST_MUL) begin
      acc_q   <= mul_a;
      cterm_q <= 27'((43'(cmul) + 43'sd8192) >>> 14);
      kterm_q <= 38'((43'(kmul) + 43'sd8) >>> 4);
    end
    if (st_q == ST_FILT) begin
      fnew_q <= fnew;
      csum_q <= 39'(cterm_q) + 39'(kterm_q);
    end
    if (st_q == ST_SUM) begin
      sum_q <= sat24(48'(tsum));
    end
  end

  // Load the output register; an ignored joint gives zero torque
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((st_q == ST_CLAMP) && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((st_q == ST_CLAMP) && out_free) begin
      joint_out_q <= joint_q;
      torque_q    <= joint_ok_q ? tq : '0;
      limited_q   <= joint_ok_q && limited;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign joint_out_o      = joint_out_q;
  assign torque_command_o = torque_q;
  assign rate_limited_o   = limited_q;

endmodule

`default_nettype wire

@@ hdl/jitl_chk.sv @@
`default_nettype none

module jitl_chk #(
  parameter int JOINTS = jitl_pkg::JointsDef
) (
  input wire                                clk_i,
  input wire                                rst_ni,
  input wire                                in_valid_i,
  input wire                                in_stall_o,
  input wire                                out_valid_o,
  input wire                                out_stall_i,
  input wire        [jitl_pkg::JointW-1:0]  joint_out_o,
  input wire signed [jitl_pkg::SigW-1:0]    torque_command_o,
  input wire                                rate_limited_o
);

  // No result is shown in the cycle after a reset edge
  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni |=> !out_valid_o)
    else $error("result valid during reset");

  // An ignored joint gives zero torque and no clamp flag
  a_ignored_joint: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (32'(joint_out_o) >= JOINTS)) |->
      (torque_command_o == '0) && !rate_limited_o)
    else $error("ignored joint returned a torque");

  // The sequencer is busy in the cycle after a transfer
  a_busy_after_xfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("sample taken while previous one in flight");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(torque_command_o) && $stable(joint_out_o)
       && $stable(rate_limited_o)))
    else $error("stalled result changed");

endmodule

bind joint_impedance_torque_law jitl_chk #(.JOINTS(JOINTS)) u_jitl_chk (.*);

`default_nettype wire
